### src/rdt_receiver_checksum_seq_unit_assert.svh
// assertion macros of the rdt receiver checksum rtl
// no dependencies; included by rdtcs_core, the file that carries assertions
`ifndef RDT_RECEIVER_CHECKSUM_SEQ_UNIT_ASSERT_SVH
`define RDT_RECEIVER_CHECKSUM_SEQ_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RDTCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RDTCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rdtcs_pkg.sv
// types and constants of the rdt receiver checksum block
// no dependencies; used by every rtl module of the block
package rdtcs_pkg;

  localparam int MAX_WORDS    = 16384;
  localparam int HEADER_WORDS = 8;

  localparam int DATA_W    = 16;
  localparam int IDX_W     = 15;
  localparam int PAYLOAD_W = 17;
  localparam int OUT_TDATA_W = 56;

  localparam logic [1:0] VERDICT_ACK = 2'd0;
  localparam logic [1:0] VERDICT_DUP = 2'd1;
  localparam logic [1:0] VERDICT_NAK = 2'd2;

  // word positions of the captured header fields
  localparam logic [IDX_W-1:0] IDX_LENGTH = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_SEQ    = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_NAME   = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_FLAGS  = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_SAT    = {IDX_W{1'b1}};

  localparam logic [DATA_W:0]   MAX_WORDS_C    = (DATA_W+1)'(MAX_WORDS);
  localparam logic [DATA_W:0]   HDR_WORDS_C    = (DATA_W+1)'(HEADER_WORDS);
  localparam logic [DATA_W-1:0] HDR_BYTES_C    = DATA_W'(2 * HEADER_WORDS);
  localparam logic [DATA_W-1:0] SUM_GOOD       = 16'hffff;
  localparam logic signed [PAYLOAD_W:0] PAYLOAD_MIN = -18'sd65535;

  typedef struct packed {
    logic [DATA_W-1:0] data_word;
    logic              last_word;
  } word_t;

  typedef struct packed {
    logic signed [PAYLOAD_W-1:0] payload_bytes;
    logic [DATA_W-1:0]           name_bytes;
    logic                        file_end;
    logic                        file_flag;
    logic [DATA_W-1:0]           seq_seen;
    logic [1:0]                  verdict;
  } result_t;

endpackage

### src/rdtcs_in_stage.sv
// input register of the rdt receiver checksum block
// depends on rdtcs_pkg
module rdtcs_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  rdtcs_pkg::word_t s_word,
  input  logic           advance,
  output logic           word_valid,
  output rdtcs_pkg::word_t word
);
  import rdtcs_pkg::*;

  logic accept;

  assign s_ready = !word_valid || advance;
  assign accept  = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (accept) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= s_word;
    end
  end

endmodule

### src/rdtcs_core.sv
// checksum, header capture and sequence tracking of the rdt receiver
// depends on rdtcs_pkg and the assertion macro header
`include "rdt_receiver_checksum_seq_unit_assert.svh"

module rdtcs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  rdtcs_pkg::word_t  word,
  output logic              res_valid,
  output rdtcs_pkg::result_t res
);
  import rdtcs_pkg::*;

  logic [DATA_W-1:0] expected_seq;
  logic [DATA_W-1:0] running_sum;
  logic [IDX_W-1:0]  word_index;
  logic [DATA_W-1:0] length_field;
  logic [DATA_W-1:0] seq_field;
  logic [DATA_W-1:0] name_length_field;
  logic [1:0]        flag_bits;

  logic [DATA_W-1:0] expected_seq_next;
  logic [DATA_W-1:0] running_sum_next;
  logic [IDX_W-1:0]  word_index_next;
  logic [DATA_W-1:0] length_field_next;
  logic [DATA_W-1:0] seq_field_next;
  logic [DATA_W-1:0] name_length_field_next;
  logic [1:0]        flag_bits_next;

  logic              first;
  logic              in_range;
  logic              add_en;
  logic [DATA_W:0]   raw_sum;
  logic [DATA_W-1:0] folded_sum;
  logic [DATA_W:0]   count;
  logic              corrupt;
  logic signed [PAYLOAD_W:0] payload_full;

  always_comb begin
    first    = (word_index == '0);
    in_range = {2'b00, word_index} < MAX_WORDS_C;

    // a new datagram starts from cleared fields
    length_field_next      = first ? '0 : length_field;
    seq_field_next         = first ? '0 : seq_field;
    name_length_field_next = first ? '0 : name_length_field;
    flag_bits_next         = first ? '0 : flag_bits;
    running_sum_next       = first ? '0 : running_sum;

    if (in_range) begin
      if (word_index == IDX_LENGTH) length_field_next      = word.data_word;
      if (word_index == IDX_SEQ)    seq_field_next         = word.data_word;
      if (word_index == IDX_NAME)   name_length_field_next = word.data_word;
      if (word_index == IDX_FLAGS)  flag_bits_next         = word.data_word[1:0];
    end

    add_en = in_range && ((word_index <= IDX_LENGTH)
                          || (word_index < length_field_next[DATA_W-1:1]));

    // ones' complement add with end-around carry
    raw_sum    = {1'b0, running_sum_next} + {1'b0, word.data_word};
    folded_sum = raw_sum[DATA_W] ? (raw_sum[DATA_W-1:0] + DATA_W'(1)) : raw_sum[DATA_W-1:0];
    if (add_en) begin
      running_sum_next = folded_sum;
    end

    count = {2'b00, word_index} + (DATA_W+1)'(1);
    if (count > MAX_WORDS_C) begin
      count = MAX_WORDS_C;
    end

    corrupt = (count < HDR_WORDS_C)
           || (length_field_next < HDR_BYTES_C)
           || (count < {2'b00, length_field_next[DATA_W-1:1]})
           || (running_sum_next != SUM_GOOD);

    payload_full = $signed({2'b00, length_field_next})
                 - $signed({2'b00, HDR_BYTES_C})
                 - $signed({2'b00, name_length_field_next});
    if (payload_full < PAYLOAD_MIN) begin
      payload_full = PAYLOAD_MIN;
    end

    expected_seq_next = expected_seq;
    if (corrupt) begin
      res.verdict = VERDICT_NAK;
    end else if (seq_field_next == expected_seq) begin
      res.verdict = VERDICT_ACK;
      if (word.last_word) begin
        // end of file with the file flag set restarts the sequence
        expected_seq_next = (flag_bits_next == 2'b11) ? '0 : expected_seq + DATA_W'(1);
      end
    end else begin
      res.verdict = VERDICT_DUP;
    end

    res.seq_seen      = seq_field_next;
    res.file_flag     = flag_bits_next[0];
    res.file_end      = flag_bits_next[1];
    res.name_bytes    = name_length_field_next;
    res.payload_bytes = payload_full[PAYLOAD_W-1:0];

    if (word.last_word) begin
      word_index_next = '0;
    end else if (word_index != IDX_SAT) begin
      word_index_next = word_index + IDX_W'(1);
    end else begin
      word_index_next = word_index;
    end
  end

  assign res_valid = take && word.last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq      <= '0;
      running_sum       <= '0;
      word_index        <= '0;
      length_field      <= '0;
      seq_field         <= '0;
      name_length_field <= '0;
      flag_bits         <= '0;
    end else if (take) begin
      expected_seq      <= expected_seq_next;
      running_sum       <= running_sum_next;
      word_index        <= word_index_next;
      length_field      <= length_field_next;
      seq_field         <= seq_field_next;
      name_length_field <= name_length_field_next;
      flag_bits         <= flag_bits_next;
    end
  end

  `RDTCS_ASSERT_NEXT(a_index_restart, clk, rst, take && word.last_word,
    word_index == '0, "word index not cleared after last word")
  `RDTCS_ASSERT_NEXT(a_index_step, clk, rst,
    take && !word.last_word && (word_index != IDX_SAT),
    word_index == $past(word_index) + IDX_W'(1), "word index did not advance")
  `RDTCS_ASSERT_NEXT(a_seq_hold, clk, rst, res_valid && (res.verdict != VERDICT_ACK),
    $stable(expected_seq), "expected sequence moved on nak or duplicate")
  `RDTCS_ASSERT_NOW(a_short_nak, clk, rst, res_valid && (word_index < IDX_FLAGS),
    res.verdict == VERDICT_NAK, "short datagram not flagged corrupt")

endmodule

### src/rdtcs_out_stage.sv
// result register of the rdt receiver checksum block
// depends on rdtcs_pkg
module rdtcs_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  rdtcs_pkg::result_t res,
  output logic               free,
  output logic               m_valid,
  input  logic               m_ready,
  output rdtcs_pkg::result_t m_res
);
  import rdtcs_pkg::*;

  assign free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (res_valid) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_res <= res;
    end
  end

endmodule

### src/rdt_receiver_checksum_seq_unit.sv
// channel  | signals                         | request
// ---------+---------------------------------+----------------------------------
// slave    | s_tvalid s_tready s_tdata s_tlast | one datagram word, tlast on last
// master   | m_tvalid m_tready m_tdata         | one verdict per datagram
//
// one word per cycle while no last word waits on a held verdict; the single-pass
// checksum add sets the pace; a verdict passes the input and result registers
// after the last word is accepted, later while an earlier verdict waits on m_tready
// input and result registers let non-last words flow while a verdict waits
// rst is synchronous, active high, and clears the sequence and datagram state
// top level of the rdt receiver checksum block; depends on rdtcs_pkg,
// rdtcs_in_stage, rdtcs_core and rdtcs_out_stage
module rdt_receiver_checksum_seq_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_word
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [rdtcs_pkg::OUT_TDATA_W-1:0] m_tdata  // verdict, seq_seen, file_flag,
                                 // file_end, name_bytes, payload_bytes, zero fill
);
  import rdtcs_pkg::*;

  word_t   s_word;
  word_t   word;
  logic    word_valid;
  logic    advance;
  logic    free;
  logic    res_valid;
  result_t res;
  result_t m_res;

  assign s_word.data_word = s_tdata;
  assign s_word.last_word = s_tlast;

  // a word that yields no result needs no room downstream
  assign advance = word_valid && (!word.last_word || free);

  rdtcs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_word     (s_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  rdtcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  rdtcs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .free      (free),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = {3'b000, m_res.payload_bytes, m_res.name_bytes, m_res.file_end,
                    m_res.file_flag, m_res.seq_seen, m_res.verdict};

endmodule
